// ----- src/eth_ipv4_tcp_header_extractor_core_macros.svh -----
// Assertion macros shared by the extractor RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ETH_IPV4_TCP_HEADER_EXTRACTOR_CORE_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_EXTRACTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define EITC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("%m: assertion failed");

// cons must hold in the same cycle as ante
`define EITC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// cons must hold in the cycle after ante
`define EITC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define EITC_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define EITC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define EITC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/eitc_pkg.sv -----
`timescale 1ns / 1ps

package eitc_pkg;

  localparam int unsigned POS_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX         = 7'd127;
  localparam logic [POS_W-1:0] ETH_HDR_LEN     = 7'd14;
  localparam logic [POS_W-1:0] TCP_OFFSET_BYTE = 7'd12;
  localparam logic [7:0]       TYPE_IPV4_HI    = 8'h08;
  localparam logic [7:0]       TYPE_IPV4_LO    = 8'h00;
  localparam logic [7:0]       PROTO_TCP       = 8'd6;

  // Header field that a byte lands in (Ethernet and IPv4 fields never overlap)
  typedef logic [3:0] hdr_sel_t;
  localparam hdr_sel_t HDR_NONE    = 4'd0;
  localparam hdr_sel_t HDR_MAC_DST = 4'd1;
  localparam hdr_sel_t HDR_MAC_SRC = 4'd2;
  localparam hdr_sel_t HDR_ETYPE   = 4'd3;
  localparam hdr_sel_t HDR_VER_IHL = 4'd4;
  localparam hdr_sel_t HDR_IP_LEN  = 4'd5;
  localparam hdr_sel_t HDR_PROTO   = 4'd6;
  localparam hdr_sel_t HDR_SRC_IP  = 4'd7;
  localparam hdr_sel_t HDR_DST_IP  = 4'd8;

  // TCP field that a byte lands in; may coincide with an IPv4 field
  typedef logic [1:0] tcp_sel_t;
  localparam tcp_sel_t TCP_NONE   = 2'd0;
  localparam tcp_sel_t TCP_SPORT  = 2'd1;
  localparam tcp_sel_t TCP_DPORT  = 2'd2;
  localparam tcp_sel_t TCP_OFFSET = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    hdr_sel_t   hdr_sel;
    tcp_sel_t   tcp_sel;
  } item_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [3:0]  ip_version;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] tcp_source_port;
    logic [15:0] tcp_dest_port;
    logic [3:0]  tcp_data_offset;
  } record_t;

  // Handshake between two internal stages
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

// ----- src/eitc_if.sv -----
`timescale 1ns / 1ps

interface eitc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eitc_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [15:0] ether_type;
  logic [3:0]  ip_version;
  logic [3:0]  ip_header_words;
  logic [15:0] ip_total_length;
  logic [7:0]  ip_protocol;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [15:0] tcp_source_port;
  logic [15:0] tcp_dest_port;
  logic [3:0]  tcp_data_offset;

  modport source (
    output valid, input ready,
    output dest_mac, output source_mac, output ether_type, output ip_version,
    output ip_header_words, output ip_total_length, output ip_protocol,
    output source_ip, output dest_ip, output tcp_source_port,
    output tcp_dest_port, output tcp_data_offset
  );
  modport sink (
    input valid, output ready,
    input dest_mac, input source_mac, input ether_type, input ip_version,
    input ip_header_words, input ip_total_length, input ip_protocol,
    input source_ip, input dest_ip, input tcp_source_port,
    input tcp_dest_port, input tcp_data_offset
  );
endinterface

// ----- src/eitc_front.sv -----
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_extractor_core_macros.svh"

module eitc_front (
  input  logic            clk,
  input  logic            rst_n,
  eitc_in_if.sink         in_chan,
  input  logic            push_ready,
  output eitc_pkg::push_t push
);

  logic [eitc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       type_hi_r, type_hi_nxt;
  logic                       ipv4_r, ipv4_nxt;
  logic [3:0]                 ihl_r, ihl_nxt;

  logic                       accept;
  logic [3:0]                 ihl;
  logic [eitc_pkg::POS_W-1:0] tcp_start;
  logic [eitc_pkg::POS_W-1:0] tcp_dport;
  logic [eitc_pkg::POS_W-1:0] tcp_end;
  logic [eitc_pkg::POS_W-1:0] tcp_off;
  eitc_pkg::hdr_sel_t         hdr_sel;
  eitc_pkg::tcp_sel_t         tcp_sel;

  assign accept = in_chan.valid && push_ready;
  assign in_chan.ready = push_ready;

  // At the version byte itself the header length comes from the byte
  assign ihl = (pos_r == eitc_pkg::ETH_HDR_LEN) ? in_chan.data_byte[3:0] : ihl_r;
  assign tcp_start = eitc_pkg::ETH_HDR_LEN + {1'b0, ihl, 2'b00};
  assign tcp_dport = tcp_start + 7'd2;
  assign tcp_end   = tcp_start + 7'd4;
  assign tcp_off   = tcp_start + eitc_pkg::TCP_OFFSET_BYTE;

  always_comb begin
    hdr_sel = eitc_pkg::HDR_NONE;
    case (pos_r) inside
      [7'd0:7'd5]:   hdr_sel = eitc_pkg::HDR_MAC_DST;
      [7'd6:7'd11]:  hdr_sel = eitc_pkg::HDR_MAC_SRC;
      [7'd12:7'd13]: hdr_sel = eitc_pkg::HDR_ETYPE;
      7'd14:         hdr_sel = ipv4_r ? eitc_pkg::HDR_VER_IHL : eitc_pkg::HDR_NONE;
      [7'd16:7'd17]: hdr_sel = ipv4_r ? eitc_pkg::HDR_IP_LEN : eitc_pkg::HDR_NONE;
      7'd23:         hdr_sel = ipv4_r ? eitc_pkg::HDR_PROTO : eitc_pkg::HDR_NONE;
      [7'd26:7'd29]: hdr_sel = ipv4_r ? eitc_pkg::HDR_SRC_IP : eitc_pkg::HDR_NONE;
      [7'd30:7'd33]: hdr_sel = ipv4_r ? eitc_pkg::HDR_DST_IP : eitc_pkg::HDR_NONE;
      default:       hdr_sel = eitc_pkg::HDR_NONE;
    endcase
  end

  always_comb begin
    tcp_sel = eitc_pkg::TCP_NONE;
    if (ipv4_r && pos_r >= eitc_pkg::ETH_HDR_LEN) begin
      if (pos_r >= tcp_start && pos_r < tcp_dport) begin
        tcp_sel = eitc_pkg::TCP_SPORT;
      end else if (pos_r >= tcp_dport && pos_r < tcp_end) begin
        tcp_sel = eitc_pkg::TCP_DPORT;
      end else if (pos_r == tcp_off) begin
        tcp_sel = eitc_pkg::TCP_OFFSET;
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    type_hi_nxt = type_hi_r;
    ipv4_nxt    = ipv4_r;
    ihl_nxt     = ihl_r;
    if (accept) begin
      if (in_chan.last_byte) begin
        pos_nxt     = '0;
        type_hi_nxt = 1'b0;
        ipv4_nxt    = 1'b0;
        ihl_nxt     = '0;
      end else begin
        if (pos_r != eitc_pkg::POS_MAX) begin
          pos_nxt = pos_r + 7'd1;
        end
        if (pos_r == 7'd12) begin
          type_hi_nxt = (in_chan.data_byte == eitc_pkg::TYPE_IPV4_HI);
        end
        if (pos_r == 7'd13) begin
          ipv4_nxt = type_hi_r && (in_chan.data_byte == eitc_pkg::TYPE_IPV4_LO);
        end
        if (pos_r == eitc_pkg::ETH_HDR_LEN && ipv4_r) begin
          ihl_nxt = in_chan.data_byte[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      type_hi_r <= 1'b0;
      ipv4_r    <= 1'b0;
      ihl_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      type_hi_r <= type_hi_nxt;
      ipv4_r    <= ipv4_nxt;
      ihl_r     <= ihl_nxt;
    end
  end

  assign push.valid          = in_chan.valid;
  assign push.item.data_byte = in_chan.data_byte;
  assign push.item.last_byte = in_chan.last_byte;
  assign push.item.hdr_sel   = hdr_sel;
  assign push.item.tcp_sel   = tcp_sel;

  `EITC_ASSERT_NEXT(a_front_restart, clk, rst_n, accept && in_chan.last_byte,
    pos_r == '0 && !ipv4_r && !type_hi_r)
  `EITC_ASSERT_IMPLY(a_front_ipv4_only_past_etype, clk, rst_n, ipv4_r,
    pos_r >= eitc_pkg::ETH_HDR_LEN)
  `EITC_ASSERT_IMPLY(a_front_tcp_needs_ipv4, clk, rst_n,
    tcp_sel != eitc_pkg::TCP_NONE, ipv4_r)

endmodule

// ----- src/eitc_queue.sv -----
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_extractor_core_macros.svh"

module eitc_queue #(
  parameter int unsigned DEPTH = eitc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  eitc_pkg::push_t push,
  output logic            push_ready,
  output eitc_pkg::push_t head,
  input  logic            pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  eitc_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_ready && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.item;
    end
  end

  `EITC_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `EITC_ASSERT_NEXT(a_queue_fill, clk, rst_n, do_push && !do_pop,
    count_r == $past(count_r) + CNT_W'(1))
  `EITC_ASSERT_IMPLY(a_queue_ptrs, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

// ----- src/eitc_back.sv -----
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_extractor_core_macros.svh"

module eitc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  eitc_pkg::push_t head,
  output logic            pop_ready,
  eitc_out_if.source      out_chan
);

  logic [47:0] dst_mac_r, dst_mac_nxt;
  logic [47:0] src_mac_r, src_mac_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  ver_ihl_r, ver_ihl_nxt;
  logic [15:0] ip_len_r, ip_len_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_ip_r, src_ip_nxt;
  logic [31:0] dst_ip_r, dst_ip_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [3:0]  tcp_off_r, tcp_off_nxt;

  logic              out_valid_r;
  eitc_pkg::record_t out_rec_r;
  eitc_pkg::record_t rec;

  logic       pop;
  logic       emit;
  logic       is_tcp;
  logic [7:0] b;

  // A plain byte always drains; the last byte waits for a free output slot
  assign pop_ready = !head.item.last_byte || !out_valid_r || out_chan.ready;
  assign pop       = head.valid && pop_ready;
  assign emit      = pop && head.item.last_byte;
  assign b         = head.item.data_byte;

  always_comb begin
    dst_mac_nxt = dst_mac_r;
    src_mac_nxt = src_mac_r;
    etype_nxt   = etype_r;
    ver_ihl_nxt = ver_ihl_r;
    ip_len_nxt  = ip_len_r;
    proto_nxt   = proto_r;
    src_ip_nxt  = src_ip_r;
    dst_ip_nxt  = dst_ip_r;
    sport_nxt   = sport_r;
    dport_nxt   = dport_r;
    tcp_off_nxt = tcp_off_r;
    if (pop) begin
      case (head.item.hdr_sel)
        eitc_pkg::HDR_MAC_DST: dst_mac_nxt = {dst_mac_r[39:0], b};
        eitc_pkg::HDR_MAC_SRC: src_mac_nxt = {src_mac_r[39:0], b};
        eitc_pkg::HDR_ETYPE:   etype_nxt   = {etype_r[7:0], b};
        eitc_pkg::HDR_VER_IHL: ver_ihl_nxt = b;
        eitc_pkg::HDR_IP_LEN:  ip_len_nxt  = {ip_len_r[7:0], b};
        eitc_pkg::HDR_PROTO:   proto_nxt   = b;
        eitc_pkg::HDR_SRC_IP:  src_ip_nxt  = {src_ip_r[23:0], b};
        eitc_pkg::HDR_DST_IP:  dst_ip_nxt  = {dst_ip_r[23:0], b};
        default: ;
      endcase
      case (head.item.tcp_sel)
        eitc_pkg::TCP_SPORT:  sport_nxt   = {sport_r[7:0], b};
        eitc_pkg::TCP_DPORT:  dport_nxt   = {dport_r[7:0], b};
        eitc_pkg::TCP_OFFSET: tcp_off_nxt = b[7:4];
        default: ;
      endcase
    end
  end

  // Build the record from the captures including the final byte
  assign is_tcp = (proto_nxt == eitc_pkg::PROTO_TCP);

  always_comb begin
    rec.dest_mac        = dst_mac_nxt;
    rec.source_mac      = src_mac_nxt;
    rec.ether_type      = etype_nxt;
    rec.ip_version      = ver_ihl_nxt[7:4];
    rec.ip_header_words = ver_ihl_nxt[3:0];
    rec.ip_total_length = ip_len_nxt;
    rec.ip_protocol     = proto_nxt;
    rec.source_ip       = src_ip_nxt;
    rec.dest_ip         = dst_ip_nxt;
    rec.tcp_source_port = is_tcp ? sport_nxt : 16'd0;
    rec.tcp_dest_port   = is_tcp ? dport_nxt : 16'd0;
    rec.tcp_data_offset = is_tcp ? tcp_off_nxt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      dst_mac_r <= '0;
      src_mac_r <= '0;
      etype_r   <= '0;
      ver_ihl_r <= '0;
      ip_len_r  <= '0;
      proto_r   <= '0;
      src_ip_r  <= '0;
      dst_ip_r  <= '0;
      sport_r   <= '0;
      dport_r   <= '0;
      tcp_off_r <= '0;
    end else begin
      dst_mac_r <= dst_mac_nxt;
      src_mac_r <= src_mac_nxt;
      etype_r   <= etype_nxt;
      ver_ihl_r <= ver_ihl_nxt;
      ip_len_r  <= ip_len_nxt;
      proto_r   <= proto_nxt;
      src_ip_r  <= src_ip_nxt;
      dst_ip_r  <= dst_ip_nxt;
      sport_r   <= sport_nxt;
      dport_r   <= dport_nxt;
      tcp_off_r <= tcp_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rec_r <= rec;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.dest_mac        = out_rec_r.dest_mac;
  assign out_chan.source_mac      = out_rec_r.source_mac;
  assign out_chan.ether_type      = out_rec_r.ether_type;
  assign out_chan.ip_version      = out_rec_r.ip_version;
  assign out_chan.ip_header_words = out_rec_r.ip_header_words;
  assign out_chan.ip_total_length = out_rec_r.ip_total_length;
  assign out_chan.ip_protocol     = out_rec_r.ip_protocol;
  assign out_chan.source_ip       = out_rec_r.source_ip;
  assign out_chan.dest_ip         = out_rec_r.dest_ip;
  assign out_chan.tcp_source_port = out_rec_r.tcp_source_port;
  assign out_chan.tcp_dest_port   = out_rec_r.tcp_dest_port;
  assign out_chan.tcp_data_offset = out_rec_r.tcp_data_offset;

  `EITC_ASSERT_NEXT(a_back_emit_clears, clk, rst_n, emit,
    out_valid_r && proto_r == '0 && etype_r == '0 && dst_mac_r == '0)
  `EITC_ASSERT_IMPLY(a_back_tcp_gate, clk, rst_n,
    out_valid_r && out_rec_r.ip_protocol != eitc_pkg::PROTO_TCP,
    out_rec_r.tcp_source_port == '0 && out_rec_r.tcp_dest_port == '0 &&
    out_rec_r.tcp_data_offset == '0)
  `EITC_ASSERT_IMPLY(a_back_no_overwrite, clk, rst_n, emit,
    !out_valid_r || out_chan.ready)

endmodule

// ----- src/eth_ipv4_tcp_header_extractor_core.sv -----
`timescale 1ns / 1ps

// Ethernet / IPv4 / TCP header extractor.
// in_chan carries one frame byte per transaction, in wire order, with
// last_byte marking the final byte. out_chan carries one header record per
// frame, sent once the last byte has been taken: MACs, EtherType, the IPv4
// fields when the EtherType is 0x0800, and the TCP ports and data offset when
// the protocol is 6. Fields whose bytes never arrived read as zero.
// Throughput: one byte per cycle while out_chan does not stall. The front end
// classifies each byte by its saturating position and feeds a small queue;
// the back end pops one byte per cycle into the capture registers, but holds
// a last byte while an unaccepted record waits. Once popped from the queue,
// the last byte completes the record, which is registered for out_chan.
// Reset (rst_n low, synchronous) empties the queue, drops any pending record
// and clears the byte position and all captures.
// When out_chan stalls, the record holds in its output register; bytes keep
// draining until the next last byte reaches the head of the queue, then the
// queue fills and in_chan.ready drops.

module eth_ipv4_tcp_header_extractor_core #(
  parameter int unsigned QUEUE_DEPTH = eitc_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  eitc_in_if.sink    in_chan,
  eitc_out_if.source out_chan
);

  eitc_pkg::push_t push;
  eitc_pkg::push_t head;
  logic            push_ready;
  logic            pop_ready;

  eitc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_ready (push_ready),
    .push       (push)
  );

  eitc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop_ready  (pop_ready)
  );

  eitc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule
